/* rtl/sscc_pkg.sv */
// Shared types, widths and register codes for the segment slab and cylinder clipper.
// Used by every module under rtl; depends on nothing.
`default_nettype none

package sscc_pkg;

    localparam int CRD_W       = 16;
    localparam int DIF_W       = CRD_W + 1;
    localparam int DEN_W       = CRD_W + 1;
    localparam int PROD_W      = DIF_W + DEN_W;
    localparam int DIVD_W      = PROD_W + 1;
    localparam int DVS_W       = DEN_W + 1;
    localparam int TRY_W       = DIVD_W + 1;
    localparam int Q_W         = DIF_W;
    localparam int DIV_STEPS   = Q_W;
    localparam int LIM_W       = 15;
    localparam int SCL_W       = 16;
    localparam int OUT_W       = 24;
    localparam int EPROD_W     = CRD_W + SCL_W + 1;
    localparam int IN_TDATA_W  = 6 * CRD_W;
    localparam int OUT_TDATA_W = 6 * OUT_W;
    localparam int CFG_AW      = 4;
    localparam int CFG_DW      = 32;
    localparam int OCC_STAGES  = 4;

    localparam logic [LIM_W-1:0]        LIM_RST   = 15'd2867;
    localparam logic signed [CRD_W-1:0] TOP_RST   = 16'sd0;
    localparam logic signed [CRD_W-1:0] BOT_RST   = -16'sd5734;
    localparam logic [SCL_W-1:0]        SCALE_RST = 16'd1152;

    typedef enum logic [1:0] {
        REG_SLAB_LIMIT  = 2'd0,
        REG_BAND_TOP    = 2'd1,
        REG_BAND_BOTTOM = 2'd2,
        REG_SCALE       = 2'd3
    } cfg_reg_e;

    typedef struct packed {
        logic signed [CRD_W-1:0] x;
        logic signed [CRD_W-1:0] y;
        logic signed [CRD_W-1:0] z;
    } pt_t;

    typedef struct packed {
        pt_t a;
        pt_t b;
    } seg_t;

    typedef struct packed {
        logic             move_a;
        logic             move_b;
        logic             pivot_b;
        logic [DEN_W-1:0] num;
        logic [DEN_W-1:0] den;
    } clip_t;

    function automatic logic signed [CRD_W-1:0] pt_crd(input pt_t p, input int unsigned k);
        logic signed [CRD_W-1:0] r;
        case (k)
            0:       r = p.x;
            1:       r = p.y;
            default: r = p.z;
        endcase
        return r;
    endfunction

    function automatic pt_t pt_put(input pt_t p, input int unsigned k,
                                   input logic signed [CRD_W-1:0] v);
        pt_t r;
        r = p;
        case (k)
            0:       r.x = v;
            1:       r.y = v;
            default: r.z = v;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

/* rtl/sscc_occl.sv */
// Band occlusion front end: hidden tests, exit candidates, exact minimum over three stages.
// Depends on sscc_pkg.
`default_nettype none

module sscc_occl (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           en,
    input  wire logic                           vld_in,
    input  wire sscc_pkg::seg_t                 seg_in,
    input  wire logic signed [sscc_pkg::CRD_W-1:0] band_top,
    input  wire logic signed [sscc_pkg::CRD_W-1:0] band_bottom,
    output logic                                vld_out,
    output sscc_pkg::seg_t                      seg_out,
    output sscc_pkg::clip_t                     clip_out
);
    import sscc_pkg::*;

    logic             o_vld_reg [OCC_STAGES];
    seg_t             o_seg_reg [OCC_STAGES];
    logic             o_mva_reg [OCC_STAGES];
    logic             o_mvb_reg [OCC_STAGES];
    logic [DEN_W-1:0] o_bn_reg  [OCC_STAGES];
    logic [DEN_W-1:0] o_bd_reg  [OCC_STAGES];
    logic             o_cnd_reg [OCC_STAGES][3];
    logic [DEN_W-1:0] o_n_reg   [OCC_STAGES][3];
    logic [DEN_W-1:0] o_d_reg   [OCC_STAGES][3];

    logic             o_vld_next;
    logic             o_mva_next, o_mvb_next;
    logic             o_cnd_next [3];
    logic [DEN_W-1:0] o_n_next [3];
    logic [DEN_W-1:0] o_d_next [3];
    logic [DEN_W-1:0] o_bn_next [1:OCC_STAGES-1];
    logic [DEN_W-1:0] o_bd_next [1:OCC_STAGES-1];

    always_comb begin
        logic ha, hb;
        pt_t  h, v;
        logic signed [DIF_W-1:0] top17, bot17, hy, vy, hz, vz;
        top17 = {band_top[CRD_W-1], band_top};
        bot17 = {band_bottom[CRD_W-1], band_bottom};
        ha = (seg_in.a.z > 16'sd1) && (seg_in.a.y < band_top) && (seg_in.a.y > band_bottom);
        hb = (seg_in.b.z > 16'sd1) && (seg_in.b.y < band_top) && (seg_in.b.y > band_bottom);
        h  = ha ? seg_in.a : seg_in.b;
        v  = ha ? seg_in.b : seg_in.a;
        hy = {h.y[CRD_W-1], h.y};
        vy = {v.y[CRD_W-1], v.y};
        hz = {h.z[CRD_W-1], h.z};
        vz = {v.z[CRD_W-1], v.z};
        o_vld_next    = vld_in && !(ha && hb);
        o_mva_next    = ha && !hb;
        o_mvb_next    = hb && !ha;
        o_cnd_next[0] = (vz <= 17'sd0) && (hz > 17'sd1);
        o_n_next[0]   = hz;
        o_d_next[0]   = hz - vz;
        o_cnd_next[1] = (vy >= top17) && (hy < top17 - 17'sd1);
        o_n_next[1]   = top17 - hy;
        o_d_next[1]   = vy - hy;
        o_cnd_next[2] = (vy <= bot17) && (hy > bot17 + 17'sd1);
        o_n_next[2]   = hy - bot17;
        o_d_next[2]   = hy - vy;
    end

    always_comb begin
        logic [PROD_W-1:0] lhs, rhs;
        for (int j = 1; j < OCC_STAGES; j++) begin
            lhs = PROD_W'(o_n_reg[j-1][j-1]) * PROD_W'(o_bd_reg[j-1]);
            rhs = PROD_W'(o_bn_reg[j-1]) * PROD_W'(o_d_reg[j-1][j-1]);
            if (o_cnd_reg[j-1][j-1] && (lhs < rhs)) begin
                o_bn_next[j] = o_n_reg[j-1][j-1];
                o_bd_next[j] = o_d_reg[j-1][j-1];
            end else begin
                o_bn_next[j] = o_bn_reg[j-1];
                o_bd_next[j] = o_bd_reg[j-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int j = 0; j < OCC_STAGES; j++) o_vld_reg[j] <= 1'b0;
        end else if (en) begin
            o_vld_reg[0] <= o_vld_next;
            for (int j = 1; j < OCC_STAGES; j++) o_vld_reg[j] <= o_vld_reg[j-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            o_seg_reg[0] <= seg_in;
            o_mva_reg[0] <= o_mva_next;
            o_mvb_reg[0] <= o_mvb_next;
            o_bn_reg[0]  <= DEN_W'(1);
            o_bd_reg[0]  <= DEN_W'(1);
            for (int k = 0; k < 3; k++) begin
                o_cnd_reg[0][k] <= o_cnd_next[k];
                o_n_reg[0][k]   <= o_n_next[k];
                o_d_reg[0][k]   <= o_d_next[k];
            end
            for (int j = 1; j < OCC_STAGES; j++) begin
                o_seg_reg[j] <= o_seg_reg[j-1];
                o_mva_reg[j] <= o_mva_reg[j-1];
                o_mvb_reg[j] <= o_mvb_reg[j-1];
                o_bn_reg[j]  <= o_bn_next[j];
                o_bd_reg[j]  <= o_bd_next[j];
                for (int k = 0; k < 3; k++) begin
                    o_cnd_reg[j][k] <= o_cnd_reg[j-1][k];
                    o_n_reg[j][k]   <= o_n_reg[j-1][k];
                    o_d_reg[j][k]   <= o_d_reg[j-1][k];
                end
            end
        end
    end

    assign vld_out          = o_vld_reg[OCC_STAGES-1];
    assign seg_out          = o_seg_reg[OCC_STAGES-1];
    assign clip_out.move_a  = o_mva_reg[OCC_STAGES-1];
    assign clip_out.move_b  = o_mvb_reg[OCC_STAGES-1];
    assign clip_out.pivot_b = o_mvb_reg[OCC_STAGES-1];
    assign clip_out.num     = o_bn_reg[OCC_STAGES-1];
    assign clip_out.den     = o_bd_reg[OCC_STAGES-1];

endmodule

`default_nettype wire

/* rtl/sscc_lerp.sv */
// Pipelined endpoint interpolator: product, restoring divide one bit a stage, add back.
// Depends on sscc_pkg.
`default_nettype none

module sscc_lerp (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            en,
    input  wire logic            vld_in,
    input  wire sscc_pkg::seg_t  seg_in,
    input  wire sscc_pkg::clip_t clip_in,
    output logic                 vld_out,
    output sscc_pkg::seg_t       seg_out
);
    import sscc_pkg::*;

    logic              l0_vld_reg;
    seg_t              l0_seg_reg;
    logic              l0_mva_reg, l0_mvb_reg, l0_pvb_reg;
    logic [DEN_W-1:0]  l0_den_reg;
    logic [PROD_W-1:0] l0_prod_reg [3];
    logic              l0_neg_reg  [3];
    logic [PROD_W-1:0] l0_prod_next [3];
    logic              l0_neg_next  [3];

    logic              d_vld_reg [DIV_STEPS+1];
    seg_t              d_seg_reg [DIV_STEPS+1];
    logic              d_mva_reg [DIV_STEPS+1];
    logic              d_mvb_reg [DIV_STEPS+1];
    logic              d_pvb_reg [DIV_STEPS+1];
    logic [DVS_W-1:0]  d_dvs_reg [DIV_STEPS+1];
    logic [DIVD_W-1:0] d_rem_reg [DIV_STEPS+1][3];
    logic [Q_W-1:0]    d_q_reg   [DIV_STEPS+1][3];
    logic              d_neg_reg [DIV_STEPS+1][3];
    logic [DIVD_W-1:0] d_rem_next [DIV_STEPS+1][3];
    logic [Q_W-1:0]    d_q_next   [DIV_STEPS+1][3];

    logic  o_vld_reg;
    seg_t  o_seg_reg;
    seg_t  o_seg_next;

    always_comb begin
        pt_t h, v;
        logic signed [DIF_W-1:0] dif;
        logic [DIF_W-1:0]        mag;
        h = clip_in.pivot_b ? seg_in.b : seg_in.a;
        v = clip_in.pivot_b ? seg_in.a : seg_in.b;
        for (int k = 0; k < 3; k++) begin
            dif = DIF_W'(pt_crd(v, k)) - DIF_W'(pt_crd(h, k));
            l0_neg_next[k]  = dif[DIF_W-1];
            mag             = dif[DIF_W-1] ? DIF_W'(-dif) : DIF_W'(dif);
            l0_prod_next[k] = PROD_W'(mag) * PROD_W'(clip_in.num);
        end
    end

    always_comb begin
        logic [TRY_W-1:0] trial;
        for (int k = 0; k < 3; k++) begin
            d_rem_next[0][k] = DIVD_W'({l0_prod_reg[k], 1'b0}) + DIVD_W'(l0_den_reg);
            d_q_next[0][k]   = '0;
        end
        for (int s = 0; s < DIV_STEPS; s++) begin
            for (int k = 0; k < 3; k++) begin
                trial = {1'b0, d_rem_reg[s][k]} - (TRY_W'(d_dvs_reg[s]) << (Q_W - 1 - s));
                d_q_next[s+1][k] = d_q_reg[s][k];
                if (!trial[TRY_W-1]) begin
                    d_rem_next[s+1][k]         = trial[DIVD_W-1:0];
                    d_q_next[s+1][k][Q_W-1-s]  = 1'b1;
                end else begin
                    d_rem_next[s+1][k] = d_rem_reg[s][k];
                end
            end
        end
    end

    always_comb begin
        pt_t h;
        logic signed [DIF_W:0] r, q;
        h = d_pvb_reg[DIV_STEPS] ? d_seg_reg[DIV_STEPS].b : d_seg_reg[DIV_STEPS].a;
        for (int k = 0; k < 3; k++) begin
            q = $signed({1'b0, d_q_reg[DIV_STEPS][k]});
            r = (DIF_W+1)'(pt_crd(h, k)) + (d_neg_reg[DIV_STEPS][k] ? -q : q);
            h = pt_put(h, k, r[CRD_W-1:0]);
        end
        o_seg_next = d_seg_reg[DIV_STEPS];
        if (d_mva_reg[DIV_STEPS]) begin
            o_seg_next.a = h;
        end else if (d_mvb_reg[DIV_STEPS]) begin
            o_seg_next.b = h;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            l0_vld_reg <= 1'b0;
            for (int s = 0; s <= DIV_STEPS; s++) d_vld_reg[s] <= 1'b0;
            o_vld_reg <= 1'b0;
        end else if (en) begin
            l0_vld_reg   <= vld_in;
            d_vld_reg[0] <= l0_vld_reg;
            for (int s = 1; s <= DIV_STEPS; s++) d_vld_reg[s] <= d_vld_reg[s-1];
            o_vld_reg <= d_vld_reg[DIV_STEPS];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            l0_seg_reg <= seg_in;
            l0_mva_reg <= clip_in.move_a;
            l0_mvb_reg <= clip_in.move_b;
            l0_pvb_reg <= clip_in.pivot_b;
            l0_den_reg <= clip_in.den;
            for (int k = 0; k < 3; k++) begin
                l0_prod_reg[k] <= l0_prod_next[k];
                l0_neg_reg[k]  <= l0_neg_next[k];
            end
            d_seg_reg[0] <= l0_seg_reg;
            d_mva_reg[0] <= l0_mva_reg;
            d_mvb_reg[0] <= l0_mvb_reg;
            d_pvb_reg[0] <= l0_pvb_reg;
            d_dvs_reg[0] <= {l0_den_reg, 1'b0};
            for (int k = 0; k < 3; k++) begin
                d_neg_reg[0][k] <= l0_neg_reg[k];
                d_rem_reg[0][k] <= d_rem_next[0][k];
                d_q_reg[0][k]   <= d_q_next[0][k];
            end
            for (int s = 1; s <= DIV_STEPS; s++) begin
                d_seg_reg[s] <= d_seg_reg[s-1];
                d_mva_reg[s] <= d_mva_reg[s-1];
                d_mvb_reg[s] <= d_mvb_reg[s-1];
                d_pvb_reg[s] <= d_pvb_reg[s-1];
                d_dvs_reg[s] <= d_dvs_reg[s-1];
                for (int k = 0; k < 3; k++) begin
                    d_neg_reg[s][k] <= d_neg_reg[s-1][k];
                    d_rem_reg[s][k] <= d_rem_next[s][k];
                    d_q_reg[s][k]   <= d_q_next[s][k];
                end
            end
            o_seg_reg <= o_seg_next;
        end
    end

    assign vld_out = o_vld_reg;
    assign seg_out = o_seg_reg;

`ifndef NO_ASSERTIONS
    a_one_side: assert property (@(posedge aclk) disable iff (!aresetn)
        (en && vld_in) |-> !(clip_in.move_a && clip_in.move_b))
        else $error("interpolator asked to move both endpoints");

    a_rem_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (d_vld_reg[DIV_STEPS] && (d_mva_reg[DIV_STEPS] || d_mvb_reg[DIV_STEPS])) |->
        ((d_rem_reg[DIV_STEPS][0] < DIVD_W'(d_dvs_reg[DIV_STEPS])) &&
         (d_rem_reg[DIV_STEPS][1] < DIVD_W'(d_dvs_reg[DIV_STEPS])) &&
         (d_rem_reg[DIV_STEPS][2] < DIVD_W'(d_dvs_reg[DIV_STEPS]))))
        else $error("divider remainder not below divisor");

    a_no_phantom: assert property (@(posedge aclk) disable iff (!aresetn)
        (en && !d_vld_reg[DIV_STEPS]) |=> !vld_out)
        else $error("interpolator output valid without a word in flight");
`endif

endmodule

`default_nettype wire

/* rtl/sscc_emit.sv */
// Output scaling: multiply by Q8.8 scale, round, saturate to Q11.12, output register.
// Depends on sscc_pkg.
`default_nettype none

module sscc_emit (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            en,
    input  wire logic                            vld_in,
    input  wire sscc_pkg::seg_t                  seg_in,
    input  wire logic [sscc_pkg::SCL_W-1:0]      scale,
    output logic                                 m_tvalid,
    output logic [sscc_pkg::OUT_TDATA_W-1:0]     m_tdata
);
    import sscc_pkg::*;

    logic                        e_vld_reg;
    logic signed [EPROD_W-1:0]   e_prod_reg [6];
    logic signed [EPROD_W-1:0]   e_prod_next [6];
    logic                        m_tvalid_reg;
    logic [OUT_TDATA_W-1:0]      m_tdata_reg;
    logic [OUT_TDATA_W-1:0]      m_tdata_next;

    always_comb begin
        logic signed [EPROD_W-1:0] sc;
        sc = $signed({{(EPROD_W-SCL_W){1'b0}}, scale});
        for (int k = 0; k < 3; k++) begin
            e_prod_next[k]   = EPROD_W'(pt_crd(seg_in.a, k)) * sc;
            e_prod_next[k+3] = EPROD_W'(pt_crd(seg_in.b, k)) * sc;
        end
    end

    always_comb begin
        logic signed [EPROD_W-1:0] sh;
        for (int k = 0; k < 6; k++) begin
            sh = (e_prod_reg[k] + EPROD_W'(128)) >>> 8;
            if (sh > EPROD_W'(8388607)) begin
                m_tdata_next[k*OUT_W +: OUT_W] = 24'h7FFFFF;
            end else if (sh < -EPROD_W'(8388608)) begin
                m_tdata_next[k*OUT_W +: OUT_W] = 24'h800000;
            end else begin
                m_tdata_next[k*OUT_W +: OUT_W] = sh[OUT_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            e_vld_reg    <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            e_vld_reg    <= vld_in;
            m_tvalid_reg <= e_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < 6; k++) e_prod_reg[k] <= e_prod_next[k];
            m_tdata_reg <= m_tdata_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

`default_nettype wire

/* rtl/segment_slab_and_cylinder_clip_top.sv */
// Top level: config registers, band occlusion, two slab clips, scaling and output register.
// Depends on sscc_pkg, sscc_occl, sscc_lerp and sscc_emit.
//
//   port group   direction   word
//   s_*          in          one segment, six Q3.12 coordinates
//   m_*          out         one clipped segment, six Q11.12 coordinates
//   p*           in/out      APB register access
//
// One word enters per cycle unless a stall on m_tready holds it; the pipeline has 4 occlusion
// stages, three interpolators of 20 stages each (one quotient bit per divide stage), 2 slab setup
// stages and 2 output stages. Dropped segments leave no word. Reset is synchronous, active
// low, and empties the pipeline. A stall on m_tready freezes the whole pipeline.
`default_nettype none

module segment_slab_and_cylinder_clip_top (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 s_tvalid,
    output logic                                      s_tready,
    input  wire logic [sscc_pkg::IN_TDATA_W-1:0]      s_tdata,  // ax, ay, az, bx, by, bz
    output logic                                      m_tvalid,
    input  wire logic                                 m_tready,
    output logic [sscc_pkg::OUT_TDATA_W-1:0]          m_tdata,  // out_ax .. out_bz
    input  wire logic                                 psel,
    input  wire logic                                 penable,
    input  wire logic                                 pwrite,
    input  wire logic [sscc_pkg::CFG_AW-1:0]          paddr,
    input  wire logic [sscc_pkg::CFG_DW-1:0]          pwdata,
    output logic [sscc_pkg::CFG_DW-1:0]               prdata,
    output logic                                      pready
);
    import sscc_pkg::*;

    logic [LIM_W-1:0]        lim_reg;
    logic signed [CRD_W-1:0] top_reg, bot_reg;
    logic [SCL_W-1:0]        scale_reg;
    logic                    wr_en, en;
    cfg_reg_e                wr_sel;

    seg_t  in_seg;
    logic  oc_vld, l0_vld, l1_vld, l2_vld;
    seg_t  oc_seg, l0_seg, l1_seg, l2_seg;
    clip_t oc_clip;

    logic  sa_vld_reg, sb_vld_reg;
    seg_t  sa_seg_reg, sb_seg_reg;
    clip_t sa_clip_reg, sb_clip_reg;
    logic  sa_vld_next;
    clip_t sa_clip_next, sb_clip_next;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign wr_sel = cfg_reg_e'(paddr[3:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lim_reg   <= LIM_RST;
            top_reg   <= TOP_RST;
            bot_reg   <= BOT_RST;
            scale_reg <= SCALE_RST;
        end else if (wr_en) begin
            unique case (wr_sel)
                REG_SLAB_LIMIT:  lim_reg   <= pwdata[LIM_W-1:0];
                REG_BAND_TOP:    top_reg   <= pwdata[CRD_W-1:0];
                REG_BAND_BOTTOM: bot_reg   <= pwdata[CRD_W-1:0];
                REG_SCALE:       scale_reg <= pwdata[SCL_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (wr_sel)
            REG_SLAB_LIMIT:  prdata = CFG_DW'(lim_reg);
            REG_BAND_TOP:    prdata = CFG_DW'(top_reg);
            REG_BAND_BOTTOM: prdata = CFG_DW'(bot_reg);
            REG_SCALE:       prdata = CFG_DW'(scale_reg);
            default:         prdata = '0;
        endcase
    end

    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    assign in_seg.a.x = s_tdata[15:0];
    assign in_seg.a.y = s_tdata[31:16];
    assign in_seg.a.z = s_tdata[47:32];
    assign in_seg.b.x = s_tdata[63:48];
    assign in_seg.b.y = s_tdata[79:64];
    assign in_seg.b.z = s_tdata[95:80];

    sscc_occl u_occl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .en          (en),
        .vld_in      (s_tvalid),
        .seg_in      (in_seg),
        .band_top    (top_reg),
        .band_bottom (bot_reg),
        .vld_out     (oc_vld),
        .seg_out     (oc_seg),
        .clip_out    (oc_clip)
    );

    sscc_lerp u_lerp_band (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .vld_in  (oc_vld),
        .seg_in  (oc_seg),
        .clip_in (oc_clip),
        .vld_out (l0_vld),
        .seg_out (l0_seg)
    );

    always_comb begin
        logic signed [DIF_W-1:0] lp, ln, ax, bx;
        logic gt_a, gt_b, lt_a, lt_b;
        lp   = $signed({2'b00, lim_reg});
        ln   = -lp;
        ax   = {l0_seg.a.x[CRD_W-1], l0_seg.a.x};
        bx   = {l0_seg.b.x[CRD_W-1], l0_seg.b.x};
        gt_a = ax > lp;
        gt_b = bx > lp;
        lt_a = ax < ln;
        lt_b = bx < ln;
        sa_vld_next          = l0_vld && !(gt_a && gt_b) && !(lt_a && lt_b);
        sa_clip_next.move_a  = gt_a;
        sa_clip_next.move_b  = gt_b && !gt_a;
        sa_clip_next.pivot_b = 1'b0;
        sa_clip_next.num     = '0;
        sa_clip_next.den     = DEN_W'(1);
        if (gt_a) begin
            sa_clip_next.pivot_b = 1'b1;
            sa_clip_next.num     = lp - bx;
            sa_clip_next.den     = ax - bx;
        end else if (gt_b) begin
            sa_clip_next.num = lp - ax;
            sa_clip_next.den = bx - ax;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sa_vld_reg <= 1'b0;
        end else if (en) begin
            sa_vld_reg <= sa_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sa_seg_reg  <= l0_seg;
            sa_clip_reg <= sa_clip_next;
        end
    end

    sscc_lerp u_lerp_pos (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .vld_in  (sa_vld_reg),
        .seg_in  (sa_seg_reg),
        .clip_in (sa_clip_reg),
        .vld_out (l1_vld),
        .seg_out (l1_seg)
    );

    always_comb begin
        logic signed [DIF_W-1:0] lp, ln, ax, bx;
        logic lt_a, lt_b;
        lp   = $signed({2'b00, lim_reg});
        ln   = -lp;
        ax   = {l1_seg.a.x[CRD_W-1], l1_seg.a.x};
        bx   = {l1_seg.b.x[CRD_W-1], l1_seg.b.x};
        lt_a = ax < ln;
        lt_b = bx < ln;
        sb_clip_next.move_a  = lt_a;
        sb_clip_next.move_b  = lt_b && !lt_a;
        sb_clip_next.pivot_b = 1'b0;
        sb_clip_next.num     = '0;
        sb_clip_next.den     = DEN_W'(1);
        if (lt_a) begin
            sb_clip_next.pivot_b = 1'b1;
            sb_clip_next.num     = bx + lp;
            sb_clip_next.den     = bx - ax;
        end else if (lt_b) begin
            sb_clip_next.num = ax + lp;
            sb_clip_next.den = ax - bx;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sb_vld_reg <= 1'b0;
        end else if (en) begin
            sb_vld_reg <= l1_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sb_seg_reg  <= l1_seg;
            sb_clip_reg <= sb_clip_next;
        end
    end

    sscc_lerp u_lerp_neg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .vld_in  (sb_vld_reg),
        .seg_in  (sb_seg_reg),
        .clip_in (sb_clip_reg),
        .vld_out (l2_vld),
        .seg_out (l2_seg)
    );

    sscc_emit u_emit (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .vld_in   (l2_vld),
        .seg_in   (l2_seg),
        .scale    (scale_reg),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata)
    );

endmodule

`default_nettype wire

/* test/segment_slab_and_cylinder_clip_top_tb.sv */
// Testbench for segment_slab_and_cylinder_clip_top: random and directed segments are streamed in,
// clipped results are predicted in-bench and compared word by word.
// Depends on sscc_pkg and the top-level RTL only.
`timescale 1ns / 100ps

module segment_slab_and_cylinder_clip_top_tb;
    import sscc_pkg::*;

    typedef struct {
        longint x;
        longint y;
        longint z;
    } vec_t;

    logic aclk;
    logic aresetn;
    logic s_tvalid;
    logic s_tready;
    logic [IN_TDATA_W-1:0] s_tdata;   // ax, ay, az, bx, by, bz (16 bits each)
    logic m_tvalid;
    logic m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;  // out_ax, out_ay, out_az, out_bx, out_by, out_bz (24 each)
    logic psel;
    logic penable;
    logic pwrite;
    logic [CFG_AW-1:0] paddr;
    logic [CFG_DW-1:0] pwdata;
    logic [CFG_DW-1:0] prdata;
    logic pready;

    segment_slab_and_cylinder_clip_top dut (.*);

    longint lim_q, top_q, bot_q, scl_q;
    logic [IN_TDATA_W-1:0] seg_pending[$];
    logic [OUT_TDATA_W-1:0] clip_expected[$];
    int errors;
    int idle_pct;
    int hold_cycles;
    int quiet;
    bit quiet_timeout;

    initial begin
        aclk = 0;
        forever #6 aclk = ~aclk;
    end

    function automatic longint rnd_div(longint n, longint d);
        if (n >= 0) return (2 * n + d) / (2 * d);
        return -((-2 * n + d) / (2 * d));
    endfunction

    function automatic vec_t interp(vec_t h, vec_t v, longint n, longint d);
        vec_t r;
        r.x = h.x + rnd_div(n * (v.x - h.x), d);
        r.y = h.y + rnd_div(n * (v.y - h.y), d);
        r.z = h.z + rnd_div(n * (v.z - h.z), d);
        return r;
    endfunction

    function automatic bit is_hidden(vec_t p);
        return p.z > 1 && p.y < top_q && p.y > bot_q;
    endfunction

    function automatic logic [OUT_W-1:0] scale_sat(longint c);
        longint p, q;
        p = c * scl_q + 128;
        q = p >= 0 ? p / 256 : -((-p + 255) / 256);
        if (q > 8388607) q = 8388607;
        if (q < -8388608) q = -8388608;
        return q[OUT_W-1:0];
    endfunction

    function automatic void predict_clip(logic [IN_TDATA_W-1:0] w);
        vec_t a, b, h, v;
        bit ha, hb;
        longint bn, bd, n, d;
        a.x = $signed(w[15:0]);  a.y = $signed(w[31:16]); a.z = $signed(w[47:32]);
        b.x = $signed(w[63:48]); b.y = $signed(w[79:64]); b.z = $signed(w[95:80]);
        ha = is_hidden(a);
        hb = is_hidden(b);
        if (ha && hb) return;
        if (ha || hb) begin
            h = ha ? a : b;
            v = ha ? b : a;
            bn = 1; bd = 1;
            if (v.z <= 0 && h.z > 1) begin
                n = h.z; d = h.z - v.z;
                if (n * bd < bn * d) begin bn = n; bd = d; end
            end
            if (v.y >= top_q && h.y < top_q - 1) begin
                n = top_q - h.y; d = v.y - h.y;
                if (n * bd < bn * d) begin bn = n; bd = d; end
            end
            if (v.y <= bot_q && h.y > bot_q + 1) begin
                n = h.y - bot_q; d = h.y - v.y;
                if (n * bd < bn * d) begin bn = n; bd = d; end
            end
            if (ha) a = interp(h, v, bn, bd); else b = interp(h, v, bn, bd);
        end
        if (a.x > lim_q && b.x > lim_q) return;
        if (a.x < -lim_q && b.x < -lim_q) return;
        if (a.x > lim_q) begin
            a = interp(b, a, lim_q - b.x, a.x - b.x);
            a.x = lim_q;
        end else if (b.x > lim_q) begin
            b = interp(a, b, lim_q - a.x, b.x - a.x);
            b.x = lim_q;
        end
        if (a.x < -lim_q) begin
            a = interp(b, a, b.x + lim_q, b.x - a.x);
            a.x = -lim_q;
        end else if (b.x < -lim_q) begin
            b = interp(a, b, a.x + lim_q, a.x - b.x);
            b.x = -lim_q;
        end
        clip_expected.push_back({scale_sat(b.z), scale_sat(b.y), scale_sat(b.x),
                                 scale_sat(a.z), scale_sat(a.y), scale_sat(a.x)});
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (seg_pending.size() > 0 && $urandom_range(99) >= idle_pct) begin
                s_tdata <= seg_pending.pop_front();
                s_tvalid <= 1'b1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge aclk) begin
        if (s_tvalid && s_tready) predict_clip(s_tdata);
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= idle_pct);
        end
    end

    always @(posedge aclk) begin
        logic [OUT_TDATA_W-1:0] exp_w;
        if (m_tvalid && m_tready) begin
            if (clip_expected.size() == 0) begin
                $display("%0t: unexpected word %h", $time, m_tdata);
                errors++;
            end else begin
                exp_w = clip_expected.pop_front();
                for (int k = 0; k < 6; k++)
                    if (m_tdata[k*OUT_W +: OUT_W] !== exp_w[k*OUT_W +: OUT_W]) begin
                        $display("%0t: field %0d expected %h actual %h", $time, k,
                                 exp_w[k*OUT_W +: OUT_W], m_tdata[k*OUT_W +: OUT_W]);
                        errors++;
                    end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn) quiet <= 0;
        else quiet <= quiet + 1;
        if (quiet > 5000) quiet_timeout <= 1'b1;
    end

    task automatic reg_write(cfg_reg_e r, logic [31:0] val);
        @(posedge aclk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= CFG_AW'(4 * int'(r)); pwdata <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (r)
            REG_SLAB_LIMIT:  lim_q = val[14:0];
            REG_BAND_TOP:    top_q = $signed(val[15:0]);
            REG_BAND_BOTTOM: bot_q = $signed(val[15:0]);
            default:         scl_q = val[15:0];
        endcase
    endtask

    task automatic drain_all();
        while (seg_pending.size() > 0 || s_tvalid || clip_expected.size() > 0)
            @(posedge aclk);
        repeat (80) @(posedge aclk);
    endtask

    function automatic logic [IN_TDATA_W-1:0] pack_seg(int ax, int ay, int az,
                                                       int bx, int by, int bz);
        return {16'(bz), 16'(by), 16'(bx), 16'(az), 16'(ay), 16'(ax)};
    endfunction

    function automatic int rcrd();
        case ($urandom_range(9))
            0: return -32768;
            1: return 32767;
            2: return $urandom_range(7) - 3;
            3, 4, 5: return $urandom_range(12000) - 6000;
            default: return $urandom_range(65535) - 32768;
        endcase
    endfunction

    task automatic random_segs(int count);
        for (int i = 0; i < count; i++)
            seg_pending.push_back(pack_seg(rcrd(), rcrd(), rcrd(), rcrd(), rcrd(), rcrd()));
    endtask

    initial begin
        errors = 0; idle_pct = 24; hold_cycles = 0; quiet = 0; quiet_timeout = 0;
        aresetn = 0; s_tvalid = 0; s_tdata = '0; m_tready = 0;
        psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
        lim_q = 2867; top_q = 0; bot_q = -5734; scl_q = 1152;
        fork
            begin
                repeat (9) @(posedge aclk);
                aresetn <= 1'b1;
                // extremes, hidden/visible mixes, slab sides and band exits
                seg_pending.push_back(pack_seg(0, -100, 100, 0, -200, 200));
                seg_pending.push_back(pack_seg(0, -100, 100, 0, 100, -100));
                seg_pending.push_back(pack_seg(100, -5000, 400, 200, -7000, 500));
                seg_pending.push_back(pack_seg(-10, 300, 500, 20, -3000, 900));
                seg_pending.push_back(pack_seg(0, -3000, 2, 0, 500, -500));
                seg_pending.push_back(pack_seg(32767, 0, 0, 32767, 1, 1));
                seg_pending.push_back(pack_seg(-32768, 0, 0, -32768, 1, 1));
                seg_pending.push_back(pack_seg(-32768, 32767, -32768, 32767, -32768, 32767));
                seg_pending.push_back(pack_seg(5000, 10, -10, -5000, 20, -20));
                seg_pending.push_back(pack_seg(-1, -1, 5, 1, -2, 6));
                drain_all();
                reg_write(REG_SLAB_LIMIT, 0);
                reg_write(REG_SCALE, 65535);
                seg_pending.push_back(pack_seg(0, 32767, -32768, 0, -32768, 32767));
                seg_pending.push_back(pack_seg(0, 5, -5, 10, 5, -5));
                random_segs(40);
                drain_all();
                reg_write(REG_SLAB_LIMIT, 32767);
                reg_write(REG_BAND_TOP, 32'h0000_8000);
                reg_write(REG_BAND_BOTTOM, 32'h0000_7fff);
                reg_write(REG_SCALE, 0);
                random_segs(30);
                drain_all();
                reg_write(REG_BAND_TOP, 32'h0000_7fff);
                reg_write(REG_BAND_BOTTOM, 32'h0000_8000);
                reg_write(REG_SCALE, 256);
                reg_write(REG_SLAB_LIMIT, 8000);
                hold_cycles = 300;
                idle_pct = 0;
                random_segs(150);
                drain_all();
                idle_pct = 24;
                reg_write(REG_BAND_TOP, 4000);
                reg_write(REG_BAND_BOTTOM, 32'hffff_f000);
                reg_write(REG_SCALE, 1152);
                reg_write(REG_SLAB_LIMIT, 2867);
                random_segs(220);
                drain_all();
                if (errors == 0) $display("All tests passed");
                else $display("Some tests failed");
                $finish;
            end
            begin
                wait (quiet_timeout);
                $display("Some tests failed");
                $finish;
            end
        join
    end
endmodule
